@@ hdl/tps_pkg.sv @@
// ----------------------------------------------------------------------------
// tps_pkg
// Shared widths, register indexes, reset values and the configuration
// record of the pitch stabiliser.
// ----------------------------------------------------------------------------
package tps_pkg;

   // field widths
   localparam int PITCH_W    = 15;
   localparam int NOTE_W     = 7;
   localparam int OFFSET_W   = 16;
   localparam int EASE_W     = 9;
   localparam int AVG_WIN_W  = 5;
   localparam int HYST_W     = 12;
   localparam int DROP_W     = 8;
   localparam int JUMP_W     = 13;
   localparam int CONF_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // default ring depth
   localparam int WINDOW_DEFAULT = 16;

   // highest displayable note
   localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_EASING       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AVG_WINDOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HYSTERESIS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DROPOUT_LIM  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_JUMP_IMM     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_JUMP_TOL     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_JUMP_CONFIRM = 3'd6;

   // register reset values
   localparam logic [EASE_W-1:0]    RST_EASING       = 9'd64;
   localparam logic [AVG_WIN_W-1:0] RST_AVG_WINDOW   = 5'd4;
   localparam logic [HYST_W-1:0]    RST_HYSTERESIS   = 12'd154;
   localparam logic [DROP_W-1:0]    RST_DROPOUT_LIM  = 8'd8;
   localparam logic [JUMP_W-1:0]    RST_JUMP_IMM     = 13'd384;
   localparam logic [JUMP_W-1:0]    RST_JUMP_TOL     = 13'd128;
   localparam logic [CONF_W-1:0]    RST_JUMP_CONFIRM = 4'd3;

   typedef struct packed {
      logic [EASE_W-1:0]    easing;
      logic [AVG_WIN_W-1:0] average_window;
      logic [HYST_W-1:0]    note_hysteresis;
      logic [DROP_W-1:0]    dropout_limit;
      logic [JUMP_W-1:0]    jump_immediate;
      logic [JUMP_W-1:0]    jump_match_tolerance;
      logic [CONF_W-1:0]    jump_confirm_frames;
   } cfg_type;

endpackage

@@ hdl/tps_ram.sv @@
// ----------------------------------------------------------------------------
// tps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/tps_divider.sv @@
// ----------------------------------------------------------------------------
// tps_divider
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// window average and the pending-pitch update.
// ----------------------------------------------------------------------------
module tps_divider #(
   parameter int DVD_W = 19,
   parameter int DVS_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DVS_W:0]   shifted;
   logic [DVS_W:0]   trial;
   logic             fits;

   // one restoring step: shift in the next dividend bit and try a subtract
   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], fits};
         rem_in = fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // hold control in reset, datapath free-running
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hdl/tps_csr.sv @@
// ----------------------------------------------------------------------------
// tps_csr
// Configuration register file of the pitch stabiliser.
// ----------------------------------------------------------------------------
module tps_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tps_pkg::CSR_DATA_W-1:0]    csr_data,
   output tps_pkg::cfg_type                  cfg
);
   import tps_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // writes are always taken; unused indexes fall through
   assign csr_ready = 1'b1;

   // decode the register index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_EASING:       cfg_in.easing               = csr_data[EASE_W-1:0];
            REG_AVG_WINDOW:   cfg_in.average_window       = csr_data[AVG_WIN_W-1:0];
            REG_HYSTERESIS:   cfg_in.note_hysteresis      = csr_data[HYST_W-1:0];
            REG_DROPOUT_LIM:  cfg_in.dropout_limit        = csr_data[DROP_W-1:0];
            REG_JUMP_IMM:     cfg_in.jump_immediate       = csr_data[JUMP_W-1:0];
            REG_JUMP_TOL:     cfg_in.jump_match_tolerance = csr_data[JUMP_W-1:0];
            REG_JUMP_CONFIRM: cfg_in.jump_confirm_frames  = csr_data[CONF_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.easing               <= RST_EASING;
         cfg_ff.average_window       <= RST_AVG_WINDOW;
         cfg_ff.note_hysteresis      <= RST_HYSTERESIS;
         cfg_ff.dropout_limit        <= RST_DROPOUT_LIM;
         cfg_ff.jump_immediate       <= RST_JUMP_IMM;
         cfg_ff.jump_match_tolerance <= RST_JUMP_TOL;
         cfg_ff.jump_confirm_frames  <= RST_JUMP_CONFIRM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/tuner_pitch_stabilizer_unit.sv @@
// ----------------------------------------------------------------------------
// tuner_pitch_stabilizer_unit
// Steadies detected pitch frames for a tuner display: jump confirmation,
// windowed average, exponential easing and hysteretic note lock.
// ----------------------------------------------------------------------------
// One frame is taken at a time and req_stall stays high until its result is
// loaded into the output register. A dropout or a frame that starts a new
// pending jump goes straight to the output state. Every pass through the
// shared bit-serial divider takes SUM_W steps, where SUM_W = 15 +
// clog2(WINDOW). A frame that matches a pending jump passes through the
// divider; if that confirms the jump, the frame goes on as an accepted frame.
// An accepted frame sums up to average_window of the newest ring entries
// (one RAM read a cycle), divides, multiplies, eases and updates the note.
// The result register lets the next frame in while a result waits. The ring
// RAM needs no clearing after reset: only entries written since the last
// restart are ever read.
// ----------------------------------------------------------------------------
module tuner_pitch_stabilizer_unit #(
   parameter int WINDOW = tps_pkg::WINDOW_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // frame input
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_has_pitch,
   input  logic [tps_pkg::PITCH_W-1:0]           req_pitch,
   // result output
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_accepted,
   output logic                                  rsp_signal_present,
   output logic [tps_pkg::PITCH_W-1:0]           rsp_smoothed_pitch,
   output logic signed [tps_pkg::OFFSET_W-1:0]   rsp_note_offset,
   output logic [tps_pkg::NOTE_W-1:0]            rsp_locked_note,
   output logic                                  rsp_note_valid,
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tps_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tps_pkg::CSR_DATA_W-1:0]        csr_data
);
   import tps_pkg::*;

   localparam int AW     = $clog2(WINDOW);
   localparam int CW     = $clog2(WINDOW + 1);
   localparam int MW     = (CW > AVG_WIN_W) ? CW : AVG_WIN_W;
   localparam int SUM_W  = PITCH_W + AW;
   localparam int DVS_W  = AVG_WIN_W;
   localparam int PROD_W = EASE_W + PITCH_W + 2;
   localparam int SW     = PROD_W + 1;

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_ADMIT = 4'd1;
   localparam logic [3:0] ST_PEND  = 4'd2;
   localparam logic [3:0] ST_PDIV  = 4'd3;
   localparam logic [3:0] ST_WRITE = 4'd4;
   localparam logic [3:0] ST_SUM   = 4'd5;
   localparam logic [3:0] ST_ADIV  = 4'd6;
   localparam logic [3:0] ST_MUL   = 4'd7;
   localparam logic [3:0] ST_EASE  = 4'd8;
   localparam logic [3:0] ST_NOTE  = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;

   cfg_type cfg;

   logic [3:0]          state_ff, state_in;
   logic                has_pitch_ff, has_pitch_in;
   logic [PITCH_W-1:0]  pitch_ff, pitch_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       wpos_ff, wpos_in;
   logic [PITCH_W-1:0]  smoothed_ff, smoothed_in;
   logic [DROP_W-1:0]   dropout_ff, dropout_in;
   logic [CONF_W-1:0]   pframes_ff, pframes_in;
   logic [PITCH_W-1:0]  ppitch_ff, ppitch_in;
   logic [NOTE_W-1:0]   note_ff, note_in;
   logic                note_valid_ff, note_valid_in;
   logic                live_ff, live_in;
   logic                acc_ff, acc_in;
   logic [MW-1:0]       n_ff, n_in;
   logic [MW-1:0]       k_ff, k_in;
   logic [AW-1:0]       rp_ff, rp_in;
   logic                issue_ff, issue_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [PITCH_W-1:0]  avg_ff, avg_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_accepted_ff, rsp_accepted_in;
   logic                    rsp_present_ff, rsp_present_in;
   logic [PITCH_W-1:0]      rsp_smoothed_ff, rsp_smoothed_in;
   logic signed [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [NOTE_W-1:0]       rsp_note_ff, rsp_note_in;
   logic                    rsp_note_valid_ff, rsp_note_valid_in;

   // ring RAM and shared divider ports
   logic                ram_we;
   logic [PITCH_W-1:0]  ram_rdata;
   logic                div_start;
   logic [SUM_W-1:0]    div_dividend;
   logic [DVS_W-1:0]    div_divisor;
   logic                div_done;
   logic [SUM_W-1:0]    div_quot;

   // datapath helpers
   logic [PITCH_W-1:0]  ad_smooth, ad_pend, ad_note, q_pend, pp_next, note_pos, s_sat;
   logic                near, match, pend_neg;
   logic [DROP_W-1:0]   drop_inc;
   logic [CONF_W-1:0]   frames_p1;
   logic [AW-1:0]       wpos_next, rp_next;
   logic [CW-1:0]       count_next;
   logic [MW-1:0]       aw_mw, cnt_mw, n_sel;
   logic [DVS_W-1:0]    n_div;
   logic signed [OFFSET_W-1:0] ease_diff;
   logic signed [EASE_W:0]     ease_s;
   logic signed [SW-1:0]       s_wide;
   logic [PITCH_W:0]    near_sum;
   logic [NOTE_W:0]     near_hi;
   logic [NOTE_W-1:0]   near_note;
   logic signed [OFFSET_W-1:0] offset_now;

   tps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tps_ram #(
      .WIDTH (PITCH_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (wpos_ff),
      .wdata (pitch_ff),
      .raddr (rp_ff),
      .rdata (ram_rdata)
   );

   tps_divider #(
      .DVD_W (SUM_W),
      .DVS_W (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // distances for the jump tests
   assign ad_smooth = (pitch_ff > smoothed_ff) ? pitch_ff - smoothed_ff
                                               : smoothed_ff - pitch_ff;
   assign ad_pend   = (pitch_ff > ppitch_ff) ? pitch_ff - ppitch_ff
                                             : ppitch_ff - pitch_ff;
   assign near      = (smoothed_ff == '0) || (ad_smooth <= PITCH_W'(cfg.jump_immediate));
   assign match     = (pframes_ff != '0)
                      && (ad_pend <= PITCH_W'(cfg.jump_match_tolerance));
   assign drop_inc  = (dropout_ff == '1) ? dropout_ff : dropout_ff + 1'b1;
   assign frames_p1 = pframes_ff + 1'b1;

   // pending pitch step, truncated toward zero
   assign pend_neg = pitch_ff < ppitch_ff;
   assign q_pend   = div_quot[PITCH_W-1:0];
   assign pp_next  = pend_neg ? ppitch_ff - q_pend : ppitch_ff + q_pend;

   // ring pointers and fill count
   assign wpos_next  = (wpos_ff == AW'(WINDOW - 1)) ? '0 : wpos_ff + 1'b1;
   assign rp_next    = (rp_ff == '0) ? AW'(WINDOW - 1) : rp_ff - 1'b1;
   assign count_next = (count_ff == CW'(WINDOW)) ? count_ff : count_ff + 1'b1;
   assign aw_mw      = MW'(cfg.average_window);
   assign cnt_mw     = MW'(count_next);
   assign n_sel      = (aw_mw < cnt_mw) ? aw_mw : cnt_mw;
   assign n_div      = n_ff[DVS_W-1:0];

   // easing: floor of the product over 256, then saturate
   assign ease_s    = signed'({1'b0, cfg.easing});
   assign ease_diff = signed'({1'b0, avg_ff}) - signed'({1'b0, smoothed_ff});
   assign s_wide    = SW'(signed'({1'b0, smoothed_ff})) + SW'(prod_ff >>> 8);
   always_comb begin
      if (smoothed_ff == '0) begin
         s_sat = avg_ff;
      end else if (s_wide < 0) begin
         s_sat = '0;
      end else if (s_wide > SW'(32767)) begin
         s_sat = '1;
      end else begin
         s_sat = s_wide[PITCH_W-1:0];
      end
   end

   // nearest note and hysteresis distance
   assign near_sum   = {1'b0, smoothed_ff} + (PITCH_W + 1)'(128);
   assign near_hi    = near_sum[PITCH_W:8];
   assign near_note  = (near_hi > {1'b0, NOTE_MAX}) ? NOTE_MAX : near_hi[NOTE_W-1:0];
   assign note_pos   = {note_ff, 8'b0};
   assign ad_note    = (smoothed_ff > note_pos) ? smoothed_ff - note_pos
                                                : note_pos - smoothed_ff;
   assign offset_now = signed'({1'b0, smoothed_ff}) - signed'({1'b0, note_pos});

   // sequencer
   always_comb begin
      state_in      = state_ff;
      has_pitch_in  = has_pitch_ff;
      pitch_in      = pitch_ff;
      count_in      = count_ff;
      wpos_in       = wpos_ff;
      smoothed_in   = smoothed_ff;
      dropout_in    = dropout_ff;
      pframes_in    = pframes_ff;
      ppitch_in     = ppitch_ff;
      note_in       = note_ff;
      note_valid_in = note_valid_ff;
      live_in       = live_ff;
      acc_in        = acc_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      rp_in         = rp_ff;
      issue_in      = 1'b0;
      sum_in        = sum_ff;
      avg_in        = avg_ff;
      prod_in       = prod_ff;
      ram_we        = 1'b0;
      div_start     = 1'b0;
      div_dividend  = sum_ff;
      div_divisor   = (n_div == '0) ? DVS_W'(1) : n_div;

      rsp_valid_in      = (rsp_valid_ff && rsp_stall);
      rsp_accepted_in   = rsp_accepted_ff;
      rsp_present_in    = rsp_present_ff;
      rsp_smoothed_in   = rsp_smoothed_ff;
      rsp_offset_in     = rsp_offset_ff;
      rsp_note_in       = rsp_note_ff;
      rsp_note_valid_in = rsp_note_valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               has_pitch_in = req_has_pitch;
               pitch_in     = req_pitch;
               state_in     = ST_ADMIT;
            end
         end
         ST_ADMIT: begin
            acc_in = 1'b0;
            if (!has_pitch_ff) begin
               // dropout: drop any pending jump, count, maybe reset all
               pframes_in = '0;
               ppitch_in  = '0;
               dropout_in = drop_inc;
               if (drop_inc >= cfg.dropout_limit) begin
                  count_in      = '0;
                  wpos_in       = '0;
                  smoothed_in   = '0;
                  dropout_in    = '0;
                  note_in       = '0;
                  note_valid_in = 1'b0;
                  live_in       = 1'b0;
               end
               state_in = ST_OUT;
            end else if (near) begin
               pframes_in = '0;
               ppitch_in  = '0;
               state_in   = ST_WRITE;
            end else begin
               state_in = ST_PEND;
            end
         end
         ST_PEND: begin
            if (!match) begin
               // start a new pending jump
               ppitch_in  = pitch_ff;
               pframes_in = CONF_W'(1);
               state_in   = ST_OUT;
            end else begin
               div_start    = 1'b1;
               div_dividend = SUM_W'(ad_pend);
               div_divisor  = DVS_W'(frames_p1);
               state_in     = ST_PDIV;
            end
         end
         ST_PDIV: begin
            if (div_done) begin
               if (frames_p1 < cfg.jump_confirm_frames) begin
                  ppitch_in  = pp_next;
                  pframes_in = frames_p1;
                  state_in   = ST_OUT;
               end else begin
                  // jump confirmed: restart the history at this pitch
                  smoothed_in = pitch_ff;
                  count_in    = '0;
                  wpos_in     = '0;
                  pframes_in  = '0;
                  ppitch_in   = '0;
                  state_in    = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            ram_we     = 1'b1;
            wpos_in    = wpos_next;
            count_in   = count_next;
            n_in       = n_sel;
            k_in       = '0;
            rp_in      = wpos_ff;
            sum_in     = '0;
            dropout_in = '0;
            live_in    = 1'b1;
            acc_in     = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            // walk back from the newest entry, one read a cycle
            if (k_ff < n_ff) begin
               k_in     = k_ff + 1'b1;
               rp_in    = rp_next;
               issue_in = 1'b1;
            end
            if (issue_ff) begin
               sum_in = sum_ff + SUM_W'(ram_rdata);
            end
            if ((k_ff == n_ff) && !issue_ff) begin
               div_start = 1'b1;
               state_in  = ST_ADIV;
            end
         end
         ST_ADIV: begin
            if (div_done) begin
               avg_in   = div_quot[PITCH_W-1:0];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(ease_s) * PROD_W'(ease_diff);
            state_in = ST_EASE;
         end
         ST_EASE: begin
            smoothed_in = s_sat;
            state_in    = ST_NOTE;
         end
         ST_NOTE: begin
            if (!note_valid_ff) begin
               note_in       = near_note;
               note_valid_in = 1'b1;
            end else if (ad_note > PITCH_W'(cfg.note_hysteresis)) begin
               note_in = near_note;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // load the result once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_accepted_in   = acc_ff;
               rsp_present_in    = live_ff;
               rsp_smoothed_in   = smoothed_ff;
               rsp_offset_in     = note_valid_ff ? offset_now : '0;
               rsp_note_in       = note_valid_ff ? note_ff : '0;
               rsp_note_valid_in = note_valid_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         wpos_ff       <= '0;
         smoothed_ff   <= '0;
         dropout_ff    <= '0;
         pframes_ff    <= '0;
         ppitch_ff     <= '0;
         note_ff       <= '0;
         note_valid_ff <= 1'b0;
         live_ff       <= 1'b0;
         acc_ff        <= 1'b0;
         k_ff          <= '0;
         n_ff          <= '0;
         rp_ff         <= '0;
         issue_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         wpos_ff       <= wpos_in;
         smoothed_ff   <= smoothed_in;
         dropout_ff    <= dropout_in;
         pframes_ff    <= pframes_in;
         ppitch_ff     <= ppitch_in;
         note_ff       <= note_in;
         note_valid_ff <= note_valid_in;
         live_ff       <= live_in;
         acc_ff        <= acc_in;
         k_ff          <= k_in;
         n_ff          <= n_in;
         rp_ff         <= rp_in;
         issue_ff      <= issue_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      has_pitch_ff      <= has_pitch_in;
      pitch_ff          <= pitch_in;
      sum_ff            <= sum_in;
      avg_ff            <= avg_in;
      prod_ff           <= prod_in;
      rsp_accepted_ff   <= rsp_accepted_in;
      rsp_present_ff    <= rsp_present_in;
      rsp_smoothed_ff   <= rsp_smoothed_in;
      rsp_offset_ff     <= rsp_offset_in;
      rsp_note_ff       <= rsp_note_in;
      rsp_note_valid_ff <= rsp_note_valid_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_accepted_ff;
   assign rsp_signal_present = rsp_present_ff;
   assign rsp_smoothed_pitch = rsp_smoothed_ff;
   assign rsp_note_offset    = rsp_offset_ff;
   assign rsp_locked_note    = rsp_note_ff;
   assign rsp_note_valid     = rsp_note_valid_ff;

   // a taken frame closes the input until its result is loaded
   a_stall_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after a frame was taken");

   // a new result appears only out of the output state
   a_result_from_out : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output state");

   // the fill count never passes the ring depth
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(WINDOW))
      else $error("ring fill count beyond depth");

   // a locked note exists only while a live signal is held
   a_note_needs_live : assert property (@(posedge clock) disable iff (reset)
      note_valid_ff |-> live_ff)
      else $error("locked note without a live signal");

endmodule
